// ===== hw/rtl/lphm_pkg.sv =====
// Shared types and codes for the linear probe hash map.
`timescale 1ns / 1ps

package lphm_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_LOOKUP = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   localparam int FIELD_BITS = 32;
   localparam int COUNT_BITS = 7;

   localparam logic [COUNT_BITS-1:0] LOAD_LIMIT_RESET = 7'd48;

endpackage

// ===== hw/rtl/lphm_if.sv =====
// Request and response channel interfaces of the linear probe hash map.
`timescale 1ns / 1ps

interface lphm_req_if;
   logic                              valid;
   logic                              ready;
   lphm_pkg::op_type                  op;
   logic [lphm_pkg::FIELD_BITS-1:0]   key;
   logic [lphm_pkg::FIELD_BITS-1:0]   key_hash;
   logic [lphm_pkg::FIELD_BITS-1:0]   value_in;

   modport source (output valid, op, key, key_hash, value_in, input ready);
   modport sink   (input valid, op, key, key_hash, value_in, output ready);
endinterface

interface lphm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [lphm_pkg::FIELD_BITS-1:0]   value_out;
   lphm_pkg::status_type              status;
   logic [lphm_pkg::COUNT_BITS-1:0]   entry_count;

   modport source (output valid, found, value_out, status, entry_count, input ready);
   modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface

// ===== hw/rtl/linear_probe_hash_map_core.sv =====
// Linear probe hash map: open addressing, tombstones, one probe slot per cycle.
//
// Usage: a request item (op, key, key_hash, value_in) enters on req_ch when
// valid and ready are both high; one response item (found, value_out, status,
// entry_count) leaves on rsp_ch under the same handshake. The csr_wr_en and
// csr_wr_data port sets the load limit; the user must write it only while
// the block is idle, and the block itself does not enforce this.
// Sequence: the idle state takes a request and issues the first slot read;
// the probe state checks slots in turn, at most CAPACITY of them; the act
// state updates the slot and loads the response register. Each slot memory
// has one read and one write port; req_ch.ready is high only between items.
// Reset: a clearing pass marks every slot empty, one slot per cycle, with
// req_ch.ready low; the live count goes to zero and the load limit to 48.
// Stall: the response register holds its item while rsp_ch.ready is low; the
// next request is still taken and probed, and waits before its slot update
// until the response register is free.
`timescale 1ns / 1ps

module linear_probe_hash_map_core #(
   parameter int CAPACITY   = 64,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   lphm_req_if.sink                          req_ch,
   lphm_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [lphm_pkg::COUNT_BITS-1:0]   csr_wr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] LAST_IDX   = AW'(CAPACITY - 1);
   localparam logic [AW:0]   LAST_PROBE = (AW + 1)'(CAPACITY - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_ACT
   } state_type;

   state_type                          state_ff;
   logic [AW-1:0]                      clear_idx_ff;
   logic [AW-1:0]                      cur_idx_ff;
   logic [AW:0]                        probes_ff;
   logic                               tomb_seen_ff;
   logic [AW-1:0]                      tomb_idx_ff;
   logic [AW-1:0]                      tgt_ff;
   logic                               hit_ff;
   logic                               have_place_ff;
   logic [VALUE_BITS-1:0]              hit_val_ff;
   lphm_pkg::op_type                   op_ff;
   logic [KEY_BITS-1:0]                key_ff;
   logic [VALUE_BITS-1:0]              val_ff;
   logic [CW-1:0]                      count_ff;
   logic [lphm_pkg::COUNT_BITS-1:0]    limit_ff;

   logic                               rsp_valid_ff;
   logic                               rsp_found_ff;
   logic [lphm_pkg::FIELD_BITS-1:0]    rsp_value_ff;
   lphm_pkg::status_type               rsp_status_ff;
   logic [lphm_pkg::COUNT_BITS-1:0]    rsp_count_ff;

   lphm_pkg::mark_type                 mark_mem [CAPACITY];
   logic [KEY_BITS-1:0]                key_mem  [CAPACITY];
   logic [VALUE_BITS-1:0]              val_mem  [CAPACITY];
   lphm_pkg::mark_type                 rd_mark_ff;
   logic [KEY_BITS-1:0]                rd_key_ff;
   logic [VALUE_BITS-1:0]              rd_val_ff;

   logic [AW-1:0]                      next_idx;
   logic [AW-1:0]                      rd_addr;
   logic [AW-1:0]                      wr_addr;
   logic                               mark_we;
   lphm_pkg::mark_type                 mark_wdata;
   logic                               key_we;
   logic                               val_we;
   logic                               act_go;
   logic                               new_ok;
   logic                               res_found;
   logic [lphm_pkg::FIELD_BITS-1:0]    res_value;
   lphm_pkg::status_type               res_status;
   logic [CW-1:0]                      count_in;
   logic                               tomb_now;

   assign next_idx = (cur_idx_ff == LAST_IDX) ? '0 : cur_idx_ff + 1'b1;
   assign act_go   = !rsp_valid_ff || rsp_ch.ready;
   assign new_ok   = !hit_ff && have_place_ff &&
                     ((32'(count_ff) + 32'd1) <= 32'(limit_ff));
   assign tomb_now = (rd_mark_ff == lphm_pkg::MARK_TOMB) && !tomb_seen_ff;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.value_out   = rsp_value_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:  rd_addr = req_ch.key_hash[AW-1:0];
         ST_PROBE: rd_addr = next_idx;
         default:  rd_addr = cur_idx_ff;
      endcase
   end

   always_comb begin
      wr_addr    = tgt_ff;
      mark_we    = 1'b0;
      mark_wdata = lphm_pkg::MARK_EMPTY;
      key_we     = 1'b0;
      val_we     = 1'b0;
      res_found  = hit_ff;
      res_value  = '0;
      res_status = lphm_pkg::STATUS_OK;
      count_in   = count_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr = clear_idx_ff;
            mark_we = 1'b1;
         end
         ST_ACT: begin
            case (op_ff)
               lphm_pkg::OP_INSERT: begin
                  if (hit_ff) begin
                     val_we = act_go;
                  end else if (new_ok) begin
                     mark_we    = act_go;
                     mark_wdata = lphm_pkg::MARK_LIVE;
                     key_we     = act_go;
                     val_we     = act_go;
                     count_in   = count_ff + 1'b1;
                  end else begin
                     res_status = lphm_pkg::STATUS_FULL;
                  end
               end
               lphm_pkg::OP_REMOVE: begin
                  if (hit_ff) begin
                     mark_we    = act_go;
                     mark_wdata = lphm_pkg::MARK_TOMB;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     res_status = lphm_pkg::STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     res_value = 32'(hit_val_ff);
                  end else begin
                     res_status = lphm_pkg::STATUS_NOT_FOUND;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[wr_addr] <= mark_wdata;
      end
      rd_mark_ff <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= val_ff;
      end
      rd_val_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         count_ff     <= '0;
         limit_ff     <= lphm_pkg::LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_ACT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + 1'b1;
               if (clear_idx_ff == LAST_IDX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_ch.valid) begin
                  op_ff         <= req_ch.op;
                  key_ff        <= KEY_BITS'(req_ch.key);
                  val_ff        <= VALUE_BITS'(req_ch.value_in);
                  cur_idx_ff    <= req_ch.key_hash[AW-1:0];
                  probes_ff     <= '0;
                  tomb_seen_ff  <= 1'b0;
                  hit_ff        <= 1'b0;
                  have_place_ff <= 1'b0;
                  state_ff      <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (tomb_now) begin
                  tomb_seen_ff <= 1'b1;
                  tomb_idx_ff  <= cur_idx_ff;
               end
               if (rd_mark_ff == lphm_pkg::MARK_EMPTY) begin
                  have_place_ff <= 1'b1;
                  tgt_ff        <= tomb_seen_ff ? tomb_idx_ff : cur_idx_ff;
                  state_ff      <= ST_ACT;
               end else if (rd_mark_ff == lphm_pkg::MARK_LIVE && rd_key_ff == key_ff) begin
                  hit_ff     <= 1'b1;
                  hit_val_ff <= rd_val_ff;
                  tgt_ff     <= cur_idx_ff;
                  state_ff   <= ST_ACT;
               end else if (probes_ff == LAST_PROBE) begin
                  have_place_ff <= tomb_seen_ff || tomb_now;
                  tgt_ff        <= tomb_seen_ff ? tomb_idx_ff : cur_idx_ff;
                  state_ff      <= ST_ACT;
               end else begin
                  cur_idx_ff <= next_idx;
                  probes_ff  <= probes_ff + 1'b1;
               end
            end
            ST_ACT: begin
               if (act_go) begin
                  count_ff      <= count_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_found_ff  <= res_found;
                  rsp_value_ff  <= res_value;
                  rsp_status_ff <= res_status;
                  rsp_count_ff  <= lphm_pkg::COUNT_BITS'(count_in);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
